/* rtl/lprn_pkg.sv */
// shared constants and types for the least-parallel-rows normal block
package lprn_pkg;

  // default entry width of the matrix inputs
  localparam int DEF_ENTRY_WIDTH = 32;

  // fixed-point layout of unit vectors
  localparam int UNIT_SHIFT  = 30;
  localparam int NORM_W      = 31;
  localparam int OUT_W       = 32;
  localparam int QUO_W       = 31;
  localparam int SQ_W        = 2 * NORM_W;
  localparam int RAD_W       = 64;
  localparam int ROOT_W      = 32;
  localparam int NUM_W       = 62;
  localparam int PROD_W      = 64;
  localparam int COS_W       = 63;
  localparam int CROSS_MAG_W = 62;

  // pair codes
  localparam logic [1:0] PAIR_01 = 2'd0;
  localparam logic [1:0] PAIR_12 = 2'd1;
  localparam logic [1:0] PAIR_20 = 2'd2;

  typedef logic signed [OUT_W-1:0] comp_t;
  typedef comp_t vec_t [3];

  // status that travels with the cross product
  typedef struct packed {
    logic       bad;
    logic [1:0] pick;
  } pair_info_t;

endpackage

/* rtl/lprn_if.sv */
// valid/ready channel interfaces for matrix input and normal output
interface lprn_in_if #(parameter int EW = 32);
  logic          valid;
  logic          ready;
  logic [EW-1:0] m00, m01, m02;
  logic [EW-1:0] m10, m11, m12;
  logic [EW-1:0] m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface

interface lprn_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic [1:0]        chosen_pair;
  logic              degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, chosen_pair, degenerate,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, chosen_pair, degenerate,
                output ready);
endinterface

/* rtl/lprn_sqrt.sv */
// pipelined integer square root, one result bit per stage
module lprn_sqrt import lprn_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = ROOT_W;

  logic              vld_r  [STEPS];
  logic [RAD_W-1:0]  v_r    [STEPS];
  logic [RAD_W-1:0]  r_r    [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  logic              vld_in  [STEPS];
  logic [RAD_W-1:0]  v_in    [STEPS];
  logic [RAD_W-1:0]  r_in    [STEPS];
  logic [SIDE_W-1:0] side_in [STEPS];

  assign vld_in[0]  = in_valid;
  assign v_in[0]    = in_rad;
  assign r_in[0]    = '0;
  assign side_in[0] = in_side;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = {{(RAD_W-1){1'b0}}, 1'b1} << (RAD_W - 2 - 2 * i);
    logic [RAD_W-1:0] t;
    logic             ge;

    // trial subtract of the next root bit
    assign t  = r_in[i] + BIT;
    assign ge = (v_in[i] >= t);

    if (i + 1 < STEPS) begin : g_link
      assign vld_in[i+1]  = vld_r[i];
      assign v_in[i+1]    = v_r[i];
      assign r_in[i+1]    = r_r[i];
      assign side_in[i+1] = side_r[i];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[i]    <= ge ? (v_in[i] - t) : v_in[i];
        r_r[i]    <= ge ? ((r_in[i] >> 1) + BIT) : (r_in[i] >> 1);
        side_r[i] <= side_in[i];
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = r_r[STEPS-1][ROOT_W-1:0];
  assign out_side  = side_r[STEPS-1];

endmodule

/* rtl/lprn_div.sv */
// three pipelined restoring dividers sharing one divisor, one quotient bit per stage
module lprn_div import lprn_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num [3],
  input  logic [ROOT_W-1:0] in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo [3],
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = QUO_W;
  localparam int REM_W = ROOT_W;

  logic              vld_r  [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS][3];
  logic [QUO_W-1:0]  low_r  [STEPS][3];
  logic [QUO_W-1:0]  quo_r  [STEPS][3];
  logic [ROOT_W-1:0] den_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  logic              vld_in  [STEPS];
  logic [REM_W-1:0]  rem_in  [STEPS][3];
  logic [QUO_W-1:0]  low_in  [STEPS][3];
  logic [QUO_W-1:0]  quo_in  [STEPS][3];
  logic [ROOT_W-1:0] den_in  [STEPS];
  logic [SIDE_W-1:0] side_in [STEPS];

  // upper numerator bits start as partial remainder, already below the divisor
  assign vld_in[0]  = in_valid;
  assign den_in[0]  = in_den;
  assign side_in[0] = in_side;
  for (genvar j = 0; j < 3; j++) begin : g_init
    assign rem_in[0][j] = REM_W'(in_num[j][NUM_W-1:QUO_W]);
    assign low_in[0][j] = in_num[j][QUO_W-1:0];
    assign quo_in[0][j] = '0;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    if (i + 1 < STEPS) begin : g_link
      assign vld_in[i+1]  = vld_r[i];
      assign den_in[i+1]  = den_r[i];
      assign side_in[i+1] = side_r[i];
      for (genvar j = 0; j < 3; j++) begin : g_lane_link
        assign rem_in[i+1][j] = rem_r[i][j];
        assign low_in[i+1][j] = low_r[i][j];
        assign quo_in[i+1][j] = quo_r[i][j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i]  <= den_in[i];
        side_r[i] <= side_in[i];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [REM_W:0] t;
      logic           ge;

      // shift in the next numerator bit and try the divisor
      assign t  = {rem_in[i][j], low_in[i][j][QUO_W-1]};
      assign ge = (t >= {1'b0, den_in[i]});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i][j] <= ge ? REM_W'(t - {1'b0, den_in[i]}) : t[REM_W-1:0];
          low_r[i][j] <= low_in[i][j] << 1;
          quo_r[i][j] <= {quo_in[i][j][QUO_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];
  for (genvar j = 0; j < 3; j++) begin : g_out
    assign out_quo[j] = quo_r[STEPS-1][j];
  end

endmodule

/* rtl/lprn_unit.sv */
// pipelined scaling of a sign/magnitude 3-vector to unit length in Q2.30
module lprn_unit import lprn_pkg::*; #(
  parameter int MAG_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_mag [3],
  input  logic [2:0]        in_neg,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output comp_t             out_u [3],
  output logic              out_zero,
  output logic [SIDE_W-1:0] out_side
);

  localparam int SH_W   = $clog2(MAG_W + 1);
  localparam int WIDE_W = MAG_W + NORM_W;
  localparam int SQS_W  = SIDE_W + 4 + 3 * NORM_W;
  localparam int DVS_W  = SIDE_W + 4;

  // stage 1: largest magnitude
  logic              v1_r;
  logic [MAG_W-1:0]  mag1_r [3];
  logic [2:0]        neg1_r;
  logic [SIDE_W-1:0] side1_r;
  logic [MAG_W-1:0]  max1_r;
  logic [MAG_W-1:0]  max01;

  assign max01 = (in_mag[1] > in_mag[0]) ? in_mag[1] : in_mag[0];

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= in_mag;
      neg1_r  <= in_neg;
      side1_r <= in_side;
      max1_r  <= (in_mag[2] > max01) ? in_mag[2] : max01;
    end
  end

  // stage 2: shift amount from top set bit
  logic              v2_r;
  logic [MAG_W-1:0]  mag2_r [3];
  logic [2:0]        neg2_r;
  logic [SIDE_W-1:0] side2_r;
  logic [SH_W-1:0]   sh2_r;
  logic              zero2_r;
  logic [SH_W-1:0]   sh_nxt;

  always_comb begin
    sh_nxt = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (max1_r[i]) begin
        sh_nxt = SH_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      side2_r <= side1_r;
      sh2_r   <= sh_nxt;
      zero2_r <= (max1_r == '0);
    end
  end

  // stage 3: normalize so the largest lies in [2^30, 2^31)
  logic              v3_r;
  logic [NORM_W-1:0] nm3_r [3];
  logic [2:0]        neg3_r;
  logic [SIDE_W-1:0] side3_r;
  logic              zero3_r;
  logic [WIDE_W-1:0] wide [3];

  for (genvar j = 0; j < 3; j++) begin : g_norm
    assign wide[j] = {mag2_r[j], {NORM_W{1'b0}}} >> sh2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        nm3_r[j] <= wide[j][NORM_W-1:0];
      end
      neg3_r  <= neg2_r;
      side3_r <= side2_r;
      zero3_r <= zero2_r;
    end
  end

  // stage 4: squares
  logic              v4_r;
  logic [SQ_W-1:0]   sq4_r [3];
  logic [NORM_W-1:0] nm4_r [3];
  logic [2:0]        neg4_r;
  logic [SIDE_W-1:0] side4_r;
  logic              zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sq4_r[j] <= SQ_W'(nm3_r[j]) * SQ_W'(nm3_r[j]);
      end
      nm4_r   <= nm3_r;
      neg4_r  <= neg3_r;
      side4_r <= side3_r;
      zero4_r <= zero3_r;
    end
  end

  // stage 5: sum of squares
  logic              v5_r;
  logic [RAD_W-1:0]  rad5_r;
  logic [NORM_W-1:0] nm5_r [3];
  logic [2:0]        neg5_r;
  logic [SIDE_W-1:0] side5_r;
  logic              zero5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad5_r  <= RAD_W'(sq4_r[0]) + RAD_W'(sq4_r[1]) + RAD_W'(sq4_r[2]);
      nm5_r   <= nm4_r;
      neg5_r  <= neg4_r;
      side5_r <= side4_r;
      zero5_r <= zero4_r;
    end
  end

  // root of the sum, magnitudes ride along
  logic              sq_valid;
  logic [ROOT_W-1:0] root;
  logic [SQS_W-1:0]  sq_side_in;
  logic [SQS_W-1:0]  sq_side_out;
  logic [NORM_W-1:0] nm_sq [3];
  logic [2:0]        neg_sq;
  logic              zero_sq;
  logic [SIDE_W-1:0] side_sq;

  assign sq_side_in = {side5_r, zero5_r, neg5_r, nm5_r[0], nm5_r[1], nm5_r[2]};
  assign {side_sq, zero_sq, neg_sq, nm_sq[0], nm_sq[1], nm_sq[2]} = sq_side_out;

  lprn_sqrt #(.SIDE_W(SQS_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v5_r),
    .in_rad   (rad5_r),
    .in_side  (sq_side_in),
    .out_valid(sq_valid),
    .out_root (root),
    .out_side (sq_side_out)
  );

  // stage 6: rounded numerators
  logic              v6_r;
  logic [NUM_W-1:0]  num6_r [3];
  logic [ROOT_W-1:0] den6_r;
  logic [DVS_W-1:0]  dside6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        num6_r[j] <= (NUM_W'(nm_sq[j]) << UNIT_SHIFT) + NUM_W'(root >> 1);
      end
      den6_r   <= root;
      dside6_r <= {side_sq, zero_sq, neg_sq};
    end
  end

  // quotients
  logic              dv_valid;
  logic [QUO_W-1:0]  quo [3];
  logic [DVS_W-1:0]  dside_out;
  logic [SIDE_W-1:0] side_dv;
  logic              zero_dv;
  logic [2:0]        neg_dv;

  assign {side_dv, zero_dv, neg_dv} = dside_out;

  lprn_div #(.SIDE_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v6_r),
    .in_num   (num6_r),
    .in_den   (den6_r),
    .in_side  (dside6_r),
    .out_valid(dv_valid),
    .out_quo  (quo),
    .out_side (dside_out)
  );

  // stage 7: apply signs, zero vector gives zeros
  logic              v7_r;
  comp_t             u7_r [3];
  logic              zero7_r;
  logic [SIDE_W-1:0] side7_r;
  comp_t             mag_q [3];

  for (genvar j = 0; j < 3; j++) begin : g_sign
    assign mag_q[j] = comp_t'({1'b0, quo[j]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        u7_r[j] <= zero_dv ? '0 : (neg_dv[j] ? -mag_q[j] : mag_q[j]);
      end
      zero7_r <= zero_dv;
      side7_r <= side_dv;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= sq_valid;
      v7_r <= dv_valid;
    end
  end

  assign out_valid = v7_r;
  assign out_u     = u7_r;
  assign out_zero  = zero7_r;
  assign out_side  = side7_r;

endmodule

/* rtl/lprn_pair.sv */
// row-pair cosines, least parallel pick and cross product of the picked pair
module lprn_pair import lprn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  vec_t                   in_row [3],
  input  logic                   in_bad,
  output logic                   out_valid,
  output logic [CROSS_MAG_W-1:0] out_mag [3],
  output logic [2:0]             out_neg,
  output pair_info_t             out_info
);

  typedef logic signed [PROD_W-1:0] prod_t;

  // stage 1: dot product terms, pair k is rows k and k+1
  logic  v1_r;
  prod_t dp1_r [3][3];
  vec_t  row1_r [3];
  logic  bad1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          dp1_r[k][c] <= prod_t'(in_row[k][c]) * prod_t'(in_row[(k + 1) % 3][c]);
        end
      end
      row1_r <= in_row;
      bad1_r <= in_bad;
    end
  end

  // stage 2: absolute cosines
  logic             v2_r;
  logic [COS_W-1:0] cos2_r [3];
  vec_t             row2_r [3];
  logic             bad2_r;
  prod_t            dot [3];

  for (genvar k = 0; k < 3; k++) begin : g_dot
    assign dot[k] = dp1_r[k][0] + dp1_r[k][1] + dp1_r[k][2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cos2_r[k] <= dot[k][PROD_W-1] ? COS_W'(-dot[k]) : COS_W'(dot[k]);
      end
      row2_r <= row1_r;
      bad2_r <= bad1_r;
    end
  end

  // stage 3: pick the smallest cosine, earlier pair wins ties
  logic       v3_r;
  vec_t       a3_r;
  vec_t       b3_r;
  logic [1:0] pick3_r;
  logic       bad3_r;
  logic [1:0] pick;
  logic [COS_W-1:0] best;

  always_comb begin
    pick = PAIR_01;
    best = cos2_r[0];
    if (cos2_r[1] < best) begin
      pick = PAIR_12;
      best = cos2_r[1];
    end
    if (cos2_r[2] < best) begin
      pick = PAIR_20;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (pick)
        PAIR_12: begin
          a3_r <= row2_r[1];
          b3_r <= row2_r[2];
        end
        PAIR_20: begin
          a3_r <= row2_r[2];
          b3_r <= row2_r[0];
        end
        default: begin
          a3_r <= row2_r[0];
          b3_r <= row2_r[1];
        end
      endcase
      pick3_r <= pick;
      bad3_r  <= bad2_r;
    end
  end

  // stage 4: cross product terms
  logic       v4_r;
  prod_t      cp4_r [6];
  logic [1:0] pick4_r;
  logic       bad4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cp4_r[0] <= prod_t'(a3_r[1]) * prod_t'(b3_r[2]);
      cp4_r[1] <= prod_t'(a3_r[2]) * prod_t'(b3_r[1]);
      cp4_r[2] <= prod_t'(b3_r[0]) * prod_t'(a3_r[2]);
      cp4_r[3] <= prod_t'(a3_r[0]) * prod_t'(b3_r[2]);
      cp4_r[4] <= prod_t'(a3_r[0]) * prod_t'(b3_r[1]);
      cp4_r[5] <= prod_t'(b3_r[0]) * prod_t'(a3_r[1]);
      pick4_r  <= pick3_r;
      bad4_r   <= bad3_r;
    end
  end

  // stage 5: differences split into sign and magnitude
  logic                   v5_r;
  logic [CROSS_MAG_W-1:0] mag5_r [3];
  logic [2:0]             neg5_r;
  pair_info_t             info5_r;
  prod_t                  cr [3];

  assign cr[0] = cp4_r[0] - cp4_r[1];
  assign cr[1] = cp4_r[2] - cp4_r[3];
  assign cr[2] = cp4_r[4] - cp4_r[5];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        neg5_r[c] <= cr[c][PROD_W-1];
        mag5_r[c] <= cr[c][PROD_W-1] ? CROSS_MAG_W'(-cr[c]) : CROSS_MAG_W'(cr[c]);
      end
      info5_r.bad  <= bad4_r;
      info5_r.pick <= pick4_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_mag   = mag5_r;
  assign out_neg   = neg5_r;
  assign out_info  = info5_r;

endmodule

/* rtl/least_parallel_rows_normal.sv */
// top level: unit normal of the least parallel row pair of a 3x3 matrix
// Takes one 3x3 matrix of signed Q16.16 entries per cycle when not stalled
// and returns the unit normal (Q2.30) of the row pair with the smallest
// absolute cosine, together with the chosen pair and a degenerate flag for a
// zero row or a zero cross product. The pipeline is fully pipelined: one
// matrix enters per cycle while not stalled. It is two unit-length scaling
// units in series (each 70 stages, dominated by a 32-stage square root and a
// 31-stage divider), the 5-stage pair select and cross product, and the
// output register. A stall on the output holds the whole pipeline; the input
// is ready whenever the output register is empty or being taken.
module least_parallel_rows_normal import lprn_pkg::*; #(
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  lprn_in_if.sink       in_ch,
  lprn_out_if.source    out_ch
);

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // sign and magnitude of each entry
  logic [ENTRY_WIDTH-1:0] ent [9];
  logic [ENTRY_WIDTH-1:0] mag [3][3];
  logic [2:0]             neg [3];

  assign ent[0] = in_ch.m00;
  assign ent[1] = in_ch.m01;
  assign ent[2] = in_ch.m02;
  assign ent[3] = in_ch.m10;
  assign ent[4] = in_ch.m11;
  assign ent[5] = in_ch.m12;
  assign ent[6] = in_ch.m20;
  assign ent[7] = in_ch.m21;
  assign ent[8] = in_ch.m22;

  for (genvar r = 0; r < 3; r++) begin : g_split
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign neg[r][c] = ent[r*3+c][ENTRY_WIDTH-1];
      assign mag[r][c] = neg[r][c] ? (~ent[r*3+c] + 1'b1) : ent[r*3+c];
    end
  end

  // row scaling
  logic  row_valid [3];
  vec_t  row_u     [3];
  logic  row_zero  [3];
  logic  row_side  [3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    lprn_unit #(.MAG_W(ENTRY_WIDTH), .SIDE_W(1)) u_row (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (in_ch.valid),
      .in_mag   (mag[r]),
      .in_neg   (neg[r]),
      .in_side  (1'b0),
      .out_valid(row_valid[r]),
      .out_u    (row_u[r]),
      .out_zero (row_zero[r]),
      .out_side (row_side[r])
    );
  end

  // pair select and cross product
  logic                   pr_valid;
  logic [CROSS_MAG_W-1:0] cr_mag [3];
  logic [2:0]             cr_neg;
  pair_info_t             pr_info;

  lprn_pair u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (row_valid[0]),
    .in_row   (row_u),
    .in_bad   (row_zero[0] || row_zero[1] || row_zero[2]),
    .out_valid(pr_valid),
    .out_mag  (cr_mag),
    .out_neg  (cr_neg),
    .out_info (pr_info)
  );

  // cross product scaling
  logic       nm_valid;
  vec_t       nm_u;
  logic       nm_zero;
  pair_info_t nm_info;

  lprn_unit #(.MAG_W(CROSS_MAG_W), .SIDE_W($bits(pair_info_t))) u_cross (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pr_valid),
    .in_mag   (cr_mag),
    .in_neg   (cr_neg),
    .in_side  (pr_info),
    .out_valid(nm_valid),
    .out_u    (nm_u),
    .out_zero (nm_zero),
    .out_side (nm_info)
  );

  // output register
  comp_t      nx_r, ny_r, nz_r;
  logic [1:0] pair_r;
  logic       deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= nm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (nm_info.bad) begin
        nx_r   <= '0;
        ny_r   <= '0;
        nz_r   <= '0;
        pair_r <= PAIR_01;
        deg_r  <= 1'b1;
      end else if (nm_zero) begin
        nx_r   <= '0;
        ny_r   <= '0;
        nz_r   <= '0;
        pair_r <= nm_info.pick;
        deg_r  <= 1'b1;
      end else begin
        nx_r   <= nm_u[0];
        ny_r   <= nm_u[1];
        nz_r   <= nm_u[2];
        pair_r <= nm_info.pick;
        deg_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.normal_x    = nx_r;
  assign out_ch.normal_y    = ny_r;
  assign out_ch.normal_z    = nz_r;
  assign out_ch.chosen_pair = pair_r;
  assign out_ch.degenerate  = deg_r;

endmodule

/* rtl/lprn_checker.sv */
// port-level checks for the least-parallel-rows normal block, with bind
module lprn_checker import lprn_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [31:0] normal_x,
  input logic signed [31:0] normal_y,
  input logic signed [31:0] normal_z,
  input logic [1:0]        chosen_pair,
  input logic              degenerate
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({normal_x, normal_y, normal_z, chosen_pair, degenerate}))
    else $error("stalled result changed");

  // input side never blocked while output is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

  // degenerate results carry a zero vector
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("degenerate result with nonzero normal");

  // pair code is a real pair
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> chosen_pair == PAIR_01 || chosen_pair == PAIR_12 ||
      chosen_pair == PAIR_20)
    else $error("bad pair code");

  // unit components stay within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824 &&
      normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824 &&
      normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
    else $error("normal component out of range");

endmodule

bind least_parallel_rows_normal lprn_checker u_lprn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .normal_x   (out_ch.normal_x),
  .normal_y   (out_ch.normal_y),
  .normal_z   (out_ch.normal_z),
  .chosen_pair(out_ch.chosen_pair),
  .degenerate (out_ch.degenerate)
);

/* verif/tb_least_parallel_rows_normal.sv */
// testbench for the least-parallel-rows unit normal block
`timescale 1ns / 1ps

module tb_least_parallel_rows_normal;
  import lprn_pkg::*;

  localparam int EW         = 32;
  localparam int RAND_ITEMS = 1730;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 200;

  typedef logic [8:0][EW-1:0] matrix_t;

  typedef struct {
    matrix_t m;
    bit      hold;   // sender waits until every result is back
  } matrix_item_t;

  typedef struct {
    comp_t      nx;
    comp_t      ny;
    comp_t      nz;
    logic [1:0] pair;
    logic       degen;
  } normal_t;

  logic clk;
  logic rst_n;

  lprn_in_if #(EW) in_ch ();
  lprn_out_if      out_ch ();

  least_parallel_rows_normal #(.ENTRY_WIDTH(EW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  matrix_item_t matrix_q[$];
  normal_t      normal_q[$];
  int           n_sent;
  int           n_seen;
  int           n_degen;
  int           pair_hits[3];
  int           errors;
  int           cycles;
  int           send_gap;
  int           recv_gap;
  int           long_stall;
  bit           stall_done;
  bit           send_calm;
  bit           recv_calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // scale a sign/magnitude vector to unit length in Q2.30; returns 0 on zero vector
  function automatic bit to_unit(input logic [2:0][63:0] mag_in, input logic [2:0] neg,
                                 output logic signed [2:0][63:0] u);
    logic [63:0] mx;
    logic [63:0] mg [3];
    logic [63:0] s;
    logic [63:0] q;
    logic [63:0] r;
    int          k;
    mx = 0;
    for (int i = 0; i < 3; i++) if (mag_in[i] > mx) mx = mag_in[i];
    u = '0;
    if (mx == 0) return 0;
    k = 0;
    while ((mx >> k) > 1) k++;
    for (int i = 0; i < 3; i++)
      mg[i] = (k < UNIT_SHIFT) ? mag_in[i] << (UNIT_SHIFT - k) : mag_in[i] >> (k - UNIT_SHIFT);
    s = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    q = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      r = ((mg[i] << UNIT_SHIFT) + q / 2) / q;
      u[i] = neg[i] ? -$signed(r) : $signed(r);
    end
    return 1;
  endfunction

  // expected normal of the least parallel row pair
  function automatic normal_t predict_normal(input matrix_t m);
    normal_t                  res;
    logic signed [2:0][63:0]  row [3];
    logic signed [2:0][63:0]  nv;
    logic signed [63:0]       cosv [3];
    logic signed [63:0]       cr [3];
    logic [2:0][63:0]         mag;
    logic [2:0]               neg;
    logic signed [63:0]       a [3];
    logic signed [63:0]       b [3];
    logic [EW-1:0]            e;
    bit                       ok;
    int                       pick;
    ok = 1;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        e = m[r * 3 + c];
        neg[c] = e[EW-1];
        mag[c] = {32'd0, (e[EW-1] ? -e : e)};
      end
      if (!to_unit(mag, neg, row[r])) ok = 0;
    end
    res = '{nx: '0, ny: '0, nz: '0, pair: PAIR_01, degen: 1'b1};
    if (!ok) return res;
    for (int p = 0; p < 3; p++) begin
      cosv[p] = row[p][0] * row[(p + 1) % 3][0] + row[p][1] * row[(p + 1) % 3][1]
              + row[p][2] * row[(p + 1) % 3][2];
      if (cosv[p] < 0) cosv[p] = -cosv[p];
    end
    pick = 0;
    for (int p = 1; p < 3; p++) if (cosv[p] < cosv[pick]) pick = p;
    for (int c = 0; c < 3; c++) begin
      a[c] = row[pick][c];
      b[c] = row[(pick + 1) % 3][c];
    end
    cr[0] = a[1] * b[2] - a[2] * b[1];
    cr[1] = b[0] * a[2] - a[0] * b[2];
    cr[2] = a[0] * b[1] - b[0] * a[1];
    for (int c = 0; c < 3; c++) begin
      neg[c] = cr[c] < 0;
      mag[c] = neg[c] ? -cr[c] : cr[c];
    end
    case (pick)
      0:       res.pair = PAIR_01;
      1:       res.pair = PAIR_12;
      default: res.pair = PAIR_20;
    endcase
    if (!to_unit(mag, neg, nv)) return res;
    res.nx    = nv[0][31:0];
    res.ny    = nv[1][31:0];
    res.nz    = nv[2][31:0];
    res.degen = 1'b0;
    return res;
  endfunction

  // random idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [EW-1:0] q16(input int whole);
    return EW'(whole) << 16;
  endfunction

  function automatic logic [EW-1:0] rand_entry(input int style);
    case (style)
      0:       return $urandom;
      1:       return EW'($signed($urandom_range(0, 65535)) - 32768);
      2:       return EW'($signed($urandom_range(0, 2000)) - 1000) << $urandom_range(0, 20);
      default: return 0;
    endcase
  endfunction

  task automatic add_matrix(input matrix_t m, input bit hold);
    matrix_item_t it;
    it.m    = m;
    it.hold = hold;
    matrix_q.push_back(it);
  endtask

  // stimulus: directed corners, then random matrices
  initial begin
    matrix_t m;
    int      style;
    int      kind;
    int      sh;
    rst_n = 1'b0;
    m = '0;
    // zero row, all zero
    add_matrix('0, 0);
    m = '0; m[0] = q16(1); m[4] = q16(1);
    add_matrix(m, 0);
    // identity: every cosine ties at zero
    m = '0; m[0] = q16(1); m[4] = q16(1); m[8] = q16(1);
    add_matrix(m, 0);
    // all extremes
    for (int i = 0; i < 9; i++) m[i] = {1'b1, {(EW-1){1'b0}}};
    add_matrix(m, 0);
    for (int i = 0; i < 9; i++) m[i] = {1'b0, {(EW-1){1'b1}}};
    add_matrix(m, 0);
    for (int i = 0; i < 9; i++) m[i] = '1;
    add_matrix(m, 0);
    for (int i = 0; i < 9; i++) m[i] = EW'(1);
    add_matrix(m, 0);
    // all rows parallel: chosen cross product vanishes
    m = '0; m[0] = q16(1); m[3] = q16(2); m[6] = -q16(3);
    add_matrix(m, 0);
    m = '0; m[1] = 5; m[4] = -7; m[7] = 9;
    add_matrix(m, 0);
    // mixed signs and extremes per row
    m = '0;
    m[0] = {1'b1, {(EW-1){1'b0}}}; m[1] = {1'b0, {(EW-1){1'b1}}}; m[2] = 1;
    m[3] = 1; m[4] = '1; m[5] = {1'b1, {(EW-1){1'b0}}};
    m[6] = q16(3); m[7] = -q16(4); m[8] = q16(12);
    add_matrix(m, 0);
    // pair 01 winning, then pair 12 winning on ties with pair 20
    m = '0; m[0] = q16(1); m[4] = q16(1); m[6] = q16(1); m[7] = q16(1);
    add_matrix(m, 0);
    m = '0; m[0] = q16(1); m[3] = q16(1); m[4] = q16(1); m[8] = q16(1);
    add_matrix(m, 0);
    m = '0; m[0] = q16(1); m[1] = q16(1); m[4] = q16(1); m[8] = q16(1);
    add_matrix(m, 0);
    m = '0; m[2] = -1; m[3] = 1; m[7] = -q16(100);
    add_matrix(m, 1);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      style = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++) m[i] = rand_entry(style);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        sh = $urandom_range(0, 2);
        for (int c = 0; c < 3; c++) m[sh * 3 + c] = 0;
      end else if (kind == 1) begin
        // one row a copy or negation of another
        sh = $urandom_range(0, 2);
        for (int c = 0; c < 3; c++)
          m[((sh + 1) % 3) * 3 + c] = $urandom_range(0, 1) ? m[sh * 3 + c] : -m[sh * 3 + c];
      end else if (kind == 2) begin
        // all rows small multiples of one row
        for (int c = 0; c < 3; c++) begin
          m[c]     = EW'($signed($urandom_range(0, 200)) - 100);
          m[3 + c] = m[c] * 3;
          m[6 + c] = -m[c] * 2;
        end
      end
      add_matrix(m, (n == 600) || (n == 1200));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // wait for everything sent, then for results to drain
    wait (matrix_q.size() == 0 && !in_ch.valid);
    @(posedge clk);
    while (n_sent != n_seen) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (normal_q.size() != 0 || out_ch.valid) begin
      $display("%0t: %0d expected results never arrived", $time, normal_q.size());
      errors++;
    end
    $display("transfers in: %0d, out: %0d, degenerate: %0d", n_sent, n_seen, n_degen);
    $display("pairs picked 01/12/20: %0d/%0d/%0d, long output stall and drain pause done",
             pair_hits[0], pair_hits[1], pair_hits[2]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.m00 <= '0; in_ch.m01 <= '0; in_ch.m02 <= '0;
      in_ch.m10 <= '0; in_ch.m11 <= '0; in_ch.m12 <= '0;
      in_ch.m20 <= '0; in_ch.m21 <= '0; in_ch.m22 <= '0;
      send_gap  <= 0;
      send_calm <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if ($urandom_range(0, 149) == 0) send_calm <= ~send_calm;
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (matrix_q.size() != 0 &&
                   !(matrix_q[0].hold && (n_sent != n_seen || in_ch.valid))) begin
        matrix_item_t it;
        it = matrix_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.m00 <= it.m[0]; in_ch.m01 <= it.m[1]; in_ch.m02 <= it.m[2];
        in_ch.m10 <= it.m[3]; in_ch.m11 <= it.m[4]; in_ch.m12 <= it.m[5];
        in_ch.m20 <= it.m[6]; in_ch.m21 <= it.m[7]; in_ch.m22 <= it.m[8];
        send_gap <= send_calm ? 0 : idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // input transfers: predict and queue
  always @(posedge clk) begin
    if (!rst_n) begin
      n_sent <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      normal_q.push_back(predict_normal({in_ch.m22, in_ch.m21, in_ch.m20,
                                         in_ch.m12, in_ch.m11, in_ch.m10,
                                         in_ch.m02, in_ch.m01, in_ch.m00}));
      n_sent <= n_sent + 1;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
      long_stall   <= 0;
      stall_done   <= 1'b0;
      recv_calm    <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) recv_calm <= ~recv_calm;
      if (!stall_done && n_seen == 300) begin
        stall_done   <= 1'b1;
        long_stall   <= 400;
        out_ch.ready <= 1'b0;
      end else if (long_stall > 0) begin
        long_stall   <= long_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap     <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap     <= recv_calm ? 0 : idle_len();
      end
    end
  end

  // output transfers: compare with oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      n_seen  <= 0;
      n_degen <= 0;
      errors  <= 0;
      pair_hits <= '{0, 0, 0};
    end else if (out_ch.valid && out_ch.ready) begin
      n_seen <= n_seen + 1;
      if (normal_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h pair=%0d degen=%b", $time,
                 out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                 out_ch.chosen_pair, out_ch.degenerate);
        errors <= errors + 1;
      end else begin
        normal_t ex;
        ex = normal_q.pop_front();
        if (ex.degen) n_degen <= n_degen + 1;
        if (ex.pair < 3) pair_hits[ex.pair] <= pair_hits[ex.pair] + 1;
        if (out_ch.normal_x !== ex.nx || out_ch.normal_y !== ex.ny ||
            out_ch.normal_z !== ex.nz || out_ch.chosen_pair !== ex.pair ||
            out_ch.degenerate !== ex.degen) begin
          $display("%0t: mismatch exp x=%h y=%h z=%h pair=%0d degen=%b", $time,
                   ex.nx, ex.ny, ex.nz, ex.pair, ex.degen);
          $display("%0t:          got x=%h y=%h z=%h pair=%0d degen=%b", $time,
                   out_ch.normal_x, out_ch.normal_y, out_ch.normal_z,
                   out_ch.chosen_pair, out_ch.degenerate);
          errors <= errors + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("%0t: timeout with %0d results pending", $time, normal_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial cycles = 0;

endmodule

/* files.f */
rtl/lprn_pkg.sv
rtl/lprn_if.sv
rtl/lprn_sqrt.sv
rtl/lprn_div.sv
rtl/lprn_unit.sv
rtl/lprn_pair.sv
rtl/least_parallel_rows_normal.sv
rtl/lprn_checker.sv
verif/tb_least_parallel_rows_normal.sv
